/* src/hnht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed next-hop table package
// Shared types, field widths and codes for the next-hop table core.
// ----------------------------------------------------------------------------
package hnht_pkg;

	localparam int DEST_W    = 8;
	localparam int HOP_W     = 8;
	localparam int ENT_W     = DEST_W + HOP_W;
	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 2;
	localparam int KEY_SPACE = 1 << DEST_W;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_SET    = 1'b1
	} hnht_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} hnht_state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} hnht_cmd_t;

	typedef struct packed {
		logic out_free;
	} hnht_sts_t;

endpackage
`default_nettype wire

/* src/hnht_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next-hop table controller
// Sequences capture of one word and the compare / write-back of its bucket.
// ----------------------------------------------------------------------------
module hnht_ctrl
	import hnht_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire hnht_sts_t sts,
	output hnht_cmd_t      cmd
);

	hnht_state_t state_q;
	hnht_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_LOOKUP: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_capture_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_LOOKUP)
		else $error("capture did not advance to lookup");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.commit}))
		else $error("capture and commit together");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP && !sts.out_free) |=> state_q == ST_LOOKUP)
		else $error("lookup left while output slot busy");
`endif

endmodule
`default_nettype wire

/* src/hnht_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next-hop table datapath
// Bucket row memory with per-row fill count, way compare, write-back and
// the output word register.
// ----------------------------------------------------------------------------
module hnht_dp
	import hnht_pkg::*;
#(
	parameter int BUCKETS = 16,
	parameter int WAYS    = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire hnht_cmd_t             cmd,
	output hnht_sts_t                  sts,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	input  wire logic [S_TUSER_W-1:0]  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,
	output logic [M_TUSER_W-1:0]       m_tuser
);

	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int CNT_W = $clog2(WAYS + 1);
	localparam int ROW_W = WAYS * ENT_W;
	localparam int MEM_W = ROW_W + CNT_W;

	logic [BW-1:0]      bucket_lut [KEY_SPACE];
	logic [DEST_W-1:0]  in_dest;
	logic [HOP_W-1:0]   in_hop;
	logic [BW-1:0]      in_bucket;

	logic [MEM_W-1:0]   mem_q [BUCKETS];
	logic [BUCKETS-1:0] row_vld_q;

	hnht_op_t           op_s1;
	logic [DEST_W-1:0]  dest_s1;
	logic [HOP_W-1:0]   hop_s1;
	logic [BW-1:0]      bucket_s1;
	logic               row_vld_s1;
	logic [MEM_W-1:0]   rd_s1;

	logic [CNT_W-1:0]   cnt;
	logic [DEST_W-1:0]  way_dest [WAYS];
	logic [HOP_W-1:0]   way_hop  [WAYS];
	logic [WAYS-1:0]    hit_oh;
	logic               hit;
	logic [HOP_W-1:0]   hit_hop;
	logic               full;
	logic               wr_en;
	logic [MEM_W-1:0]   wr_row;

	logic               m_tvalid_q;
	logic               found_q;
	logic [HOP_W-1:0]   hop_q;
	logic               full_q;

	for (genvar g = 0; g < KEY_SPACE; g++) begin : g_lut
		assign bucket_lut[g] = BW'(g % BUCKETS);
	end

	assign in_dest   = s_tdata[DEST_W-1:0];
	assign in_hop    = s_tdata[DEST_W +: HOP_W];
	assign in_bucket = bucket_lut[in_dest];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1     <= hnht_op_t'(s_tuser[0]);
			dest_s1   <= in_dest;
			hop_s1    <= in_hop;
			bucket_s1 <= in_bucket;
			rd_s1     <= mem_q[in_bucket];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[bucket_s1] <= wr_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q  <= '0;
			row_vld_s1 <= 1'b0;
		end else begin
			if (cmd.capture) row_vld_s1 <= row_vld_q[in_bucket];
			if (wr_en)       row_vld_q[bucket_s1] <= 1'b1;
		end
	end

	always_comb begin
		cnt     = row_vld_s1 ? rd_s1[ROW_W +: CNT_W] : '0;
		hit     = 1'b0;
		hit_oh  = '0;
		hit_hop = '0;
		for (int w = 0; w < WAYS; w++) begin
			way_dest[w] = rd_s1[w*ENT_W +: DEST_W];
			way_hop[w]  = rd_s1[w*ENT_W + DEST_W +: HOP_W];
			if (!hit && (CNT_W'(w) < cnt) && (way_dest[w] == dest_s1)) begin
				hit       = 1'b1;
				hit_oh[w] = 1'b1;
				hit_hop   = way_hop[w];
			end
		end
		full = (cnt == CNT_W'(WAYS));
	end

	always_comb begin
		wr_row = rd_s1;
		for (int w = 0; w < WAYS; w++) begin
			if (hit) begin
				if (hit_oh[w]) wr_row[w*ENT_W + DEST_W +: HOP_W] = hop_s1;
			end else if (CNT_W'(w) == cnt) begin
				wr_row[w*ENT_W +: ENT_W] = {hop_s1, dest_s1};
			end
		end
		if (!hit) wr_row[ROW_W +: CNT_W] = cnt + CNT_W'(1);
		wr_en = cmd.commit && (op_s1 == OP_SET) && (hit || !full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			found_q <= hit;
			hop_q   <= (op_s1 == OP_LOOKUP && hit) ? hit_hop : '0;
			full_q  <= (op_s1 == OP_SET) && !hit && full;
		end
	end

	assign sts.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = hop_q;
	assign m_tuser      = {full_q, found_q};

`ifndef SYNTHESIS
	a_commit_shows_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed word not presented");

	a_found_full_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(found_q && full_q))
		else $error("found and bucket_full both set");

	a_write_only_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (cmd.commit && op_s1 == OP_SET))
		else $error("table written outside a set commit");
`endif

endmodule
`default_nettype wire

/* src/hashed_next_hop_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed next-hop table core
// Route table keyed by destination node: set or look up a next hop in a
// bucket of WAYS entries chosen by dest_node modulo BUCKETS.
// ----------------------------------------------------------------------------
// Result: the input word and its bucket row are registered at capture; the
// result word is registered at commit, once the output slot is free. No new
// word is taken until then; compare and write-back to the row memory follow.
// Reset: arst_n clears the row valid flags, so the table comes up empty with
// no clearing pass; the output register comes up empty.
module hashed_next_hop_table_core
	import hnht_pkg::*;
#(
	parameter int BUCKETS = 16,
	parameter int WAYS    = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // dest_node[7:0], new_next_hop[15:8]
	input  wire logic [S_TUSER_W-1:0]  s_tuser,   // operation[0]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,   // next_hop[7:0]
	output logic [M_TUSER_W-1:0]       m_tuser    // found[0], bucket_full[1]
);

	hnht_cmd_t cmd;
	hnht_sts_t sts;

	hnht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hnht_dp #(
		.BUCKETS (BUCKETS),
		.WAYS    (WAYS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

/* test/hashed_next_hop_table_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed next-hop table core testbench
// Drives set and lookup words into the core, with random gaps on both sides
// and one long output stall. A local copy of the bucket table predicts each
// result word, and every result word is checked field by field in order.
// ----------------------------------------------------------------------------
module hashed_next_hop_table_core_tb;
	import hnht_pkg::*;

	localparam int BUCKETS = 16;
	localparam int WAYS    = 4;
	localparam int ENTRIES = BUCKETS * WAYS;

	typedef struct {
		logic       found;
		logic [7:0] next_hop;
		logic       bucket_full;
	} route_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	logic       tbl_valid [ENTRIES];
	logic [7:0] tbl_dest  [ENTRIES];
	logic [7:0] tbl_hop   [ENTRIES];
	logic [7:0] installed_dests [$];

	route_result_t pending_routes [$];
	route_result_t oldest_route;

	int  mismatch_count = 0;
	int  hold_cycles    = 0;
	int  stall_left     = 0;
	bit  idle_on        = 1'b1;

	hashed_next_hop_table_core #(
		.BUCKETS(BUCKETS),
		.WAYS   (WAYS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),   // dest_node[7:0], new_next_hop[15:8]
		.s_tuser (s_tuser),   // operation[0]
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),   // next_hop[7:0]
		.m_tuser (m_tuser)    // found[0], bucket_full[1]
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic route_result_t predict_route(hnht_op_t op, logic [7:0] dest,
			logic [7:0] hop);
		route_result_t res;
		int base;
		int hit_idx;
		int free_idx;
		res      = '{1'b0, 8'd0, 1'b0};
		base     = (int'(dest) % BUCKETS) * WAYS;
		hit_idx  = -1;
		free_idx = -1;
		for (int w = 0; w < WAYS; w++) begin
			if (tbl_valid[base + w]) begin
				if (hit_idx < 0 && tbl_dest[base + w] == dest)
					hit_idx = base + w;
			end else if (free_idx < 0) begin
				free_idx = base + w;
			end
		end
		if (op == OP_LOOKUP) begin
			if (hit_idx >= 0) begin
				res.found    = 1'b1;
				res.next_hop = tbl_hop[hit_idx];
			end
		end else if (hit_idx >= 0) begin
			tbl_hop[hit_idx] = hop;
			res.found        = 1'b1;
		end else if (free_idx >= 0) begin
			tbl_valid[free_idx] = 1'b1;
			tbl_dest[free_idx]  = dest;
			tbl_hop[free_idx]   = hop;
			installed_dests.push_back(dest);
		end else begin
			res.bucket_full = 1'b1;
		end
		return res;
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic send_word(hnht_op_t op, logic [7:0] dest, logic [7:0] hop);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {hop, dest};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		pending_routes.push_back(predict_route(op, dest, hop));
	endtask

	// receiver: random stalls, and a long hold when the backpressure test sets one
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready   <= 1'b1;
				stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_routes.size() == 0) begin
				report_mismatch("result word with no pending request");
			end else begin
				oldest_route = pending_routes.pop_front();
				if (m_tuser[0] !== oldest_route.found)
					report_mismatch($sformatf("found %b, want %b", m_tuser[0],
						oldest_route.found));
				if (m_tdata !== oldest_route.next_hop)
					report_mismatch($sformatf("next_hop %0d, want %0d", m_tdata,
						oldest_route.next_hop));
				if (m_tuser[1] !== oldest_route.bucket_full)
					report_mismatch($sformatf("bucket_full %b, want %b", m_tuser[1],
						oldest_route.bucket_full));
			end
		end
	end

	task automatic test_empty_table();
		send_word(OP_LOOKUP, 8'd0, 8'd255);
		send_word(OP_LOOKUP, 8'd255, 8'd0);
	endtask

	task automatic test_set_update();
		send_word(OP_SET, 8'd0, 8'd255);
		send_word(OP_SET, 8'd255, 8'd0);
		send_word(OP_LOOKUP, 8'd0, 8'd0);
		send_word(OP_LOOKUP, 8'd255, 8'd255);
		send_word(OP_SET, 8'd0, 8'hAA);
		send_word(OP_LOOKUP, 8'd0, 8'd0);
		send_word(OP_LOOKUP, 8'd16, 8'd0);
	endtask

	task automatic test_full_bucket();
		send_word(OP_SET, 8'd5, 8'd11);
		send_word(OP_SET, 8'd21, 8'd22);
		send_word(OP_SET, 8'd37, 8'd33);
		send_word(OP_SET, 8'd53, 8'd44);
		send_word(OP_SET, 8'd69, 8'd55);
		send_word(OP_LOOKUP, 8'd69, 8'd0);
		send_word(OP_SET, 8'd21, 8'd99);
		send_word(OP_LOOKUP, 8'd21, 8'd0);
		send_word(OP_LOOKUP, 8'd53, 8'd0);
		send_word(OP_SET, 8'd245, 8'd200);
		send_word(OP_SET, 8'd245, 8'd201);
		send_word(OP_LOOKUP, 8'd245, 8'd0);
	endtask

	task automatic test_backpressure();
		idle_on     = 1'b0;
		hold_cycles = 200;
		for (int i = 0; i < 24; i++)
			send_word(($urandom_range(0, 1) == 1) ? OP_SET : OP_LOOKUP,
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic(int count);
		hnht_op_t   op;
		logic [7:0] dest;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			op = ($urandom_range(0, 1) == 1) ? OP_SET : OP_LOOKUP;
			if (installed_dests.size() > 0 && $urandom_range(0, 9) < 6)
				dest = installed_dests[$urandom_range(0, installed_dests.size() - 1)];
			else
				dest = 8'($urandom_range(0, 255));
			send_word(op, dest, 8'($urandom_range(0, 255)));
		end
		idle_on = 1'b1;
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_dest[i]  = 8'd0;
			tbl_hop[i]   = 8'd0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_set_update();
		test_full_bucket();
		test_backpressure();
		test_random_traffic(1750);
		s_tvalid <= 1'b0;
		while (pending_routes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* hashed_next_hop_table_core.f */
src/hnht_pkg.sv
src/hnht_ctrl.sv
src/hnht_dp.sv
src/hashed_next_hop_table_core.sv
test/hashed_next_hop_table_core_tb.sv
